>>> rtl/core/msort_pkg.sv
package msort_pkg;

	// fixed field widths on the stream ports
	localparam int KEY_FIELD_W = 32;
	localparam int PAY_FIELD_W = 16;
	localparam int TDATA_W     = KEY_FIELD_W + PAY_FIELD_W;

	// position width sized for the largest supported capacity (64 records)
	localparam int POS_W = 7;

	// one merge job: span starts at lo, splits after half, covers len records
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] half;
		logic [POS_W-1:0] len;
	} msort_job_t;

endpackage

>>> rtl/core/merge_sort_engine.sv
// Record sorter: collects a set of records, sorts them ascending by key and
// streams them back out.
// Input channel (s_*): one record per transfer, key and payload in s_tdata,
//   s_tlast on the final record of the set. Records past MAX_ITEMS are
//   dropped and flagged. s_tready is high only while collecting.
// Output channel (m_*): one sorted record per transfer, m_tlast on the last
//   one, m_tuser set on every record of a set that lost records.
// Equal keys: the record from the right half of a merge leaves first.
// Sorting is a top-down merge sort over a record RAM and a scratch RAM.
//   Each merge steps the span stack, takes the job, fetches the two
//   heads, moves records to scratch, copies them back and reports done.
// Output: each record is read from the record RAM ahead of the output
//   register; the next read waits until that one has reached it.
// Reset clears all control state; RAM contents are left as they are.
// A stalled receiver holds the output register; the block then waits
// before the next read. Collection of the next set starts as soon as the
// read of the last record is issued.
module merge_sort_engine import msort_pkg::*; #(
	parameter int MAX_ITEMS    = 64,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // record_key [31:0], record_payload [47:32]
	input  logic               s_tlast,   // final_record
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // sorted_key [31:0], sorted_payload [47:32]
	output logic               m_tlast,   // last_out
	output logic               m_tuser    // overflowed
);

	localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
	localparam int PW = (PAYLOAD_BITS < PAY_FIELD_W) ? PAYLOAD_BITS : PAY_FIELD_W;
	localparam int DW = KW + PW;
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

	typedef enum logic [1:0] {T_LOAD, T_SORT, T_EMIT} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;     // records held in the current set
	logic          ovf_q;       // set lost a record
	logic [CW-1:0] n_q;         // size of the set being sorted / sent
	logic          ovf_run_q;
	logic          sort_start_q;
	logic [CW-1:0] k_q;         // next record to read out
	logic          rd_pend_s1;  // record RAM read in flight to the output
	logic          last_s1;

	logic          in_xfer;
	logic          store;
	logic          emit_issue;

	// record RAM ports
	logic          rec_we, rec_re;
	logic [AW-1:0] rec_waddr, rec_raddr;
	logic [DW-1:0] rec_wdata, rec_rdata;

	// merger side
	msort_job_t    job;
	logic          merge_done;
	logic          sort_finished;
	logic          mg_rec_re, mg_rec_we;
	logic [AW-1:0] mg_rec_raddr, mg_rec_waddr;
	logic [DW-1:0] mg_rec_wdata;
	logic          scr_we, scr_re;
	logic [AW-1:0] scr_waddr, scr_raddr;
	logic [DW-1:0] scr_wdata, scr_rdata;

	assign s_tready   = (state_q == T_LOAD);
	assign in_xfer    = s_tvalid && s_tready;
	assign store      = in_xfer && (count_q != CAP);
	assign emit_issue = (state_q == T_EMIT) && !rd_pend_s1 && (!m_tvalid || m_tready);

	// loading and copy-back never overlap; neither do merging and read-out
	always_comb begin
		if (store) begin
			rec_we    = 1'b1;
			rec_waddr = count_q[AW-1:0];
			rec_wdata = {s_tdata[KW-1:0], s_tdata[KEY_FIELD_W +: PW]};
		end else begin
			rec_we    = mg_rec_we;
			rec_waddr = mg_rec_waddr;
			rec_wdata = mg_rec_wdata;
		end
		if (state_q == T_EMIT) begin
			rec_re    = emit_issue;
			rec_raddr = k_q[AW-1:0];
		end else begin
			rec_re    = mg_rec_re;
			rec_raddr = mg_rec_raddr;
		end
	end

	msort_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_record_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	msort_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_scratch_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.re    (scr_re),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	msort_span_stack #(.MAX_ITEMS(MAX_ITEMS)) u_span_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (sort_start_q),
		.span_len   (n_q),
		.merge_done (merge_done),
		.job        (job),
		.finished   (sort_finished)
	);

	msort_merger #(.MAX_ITEMS(MAX_ITEMS), .DW(DW), .KW(KW)) u_merger (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job),
		.done        (merge_done),
		.rec_rd_en   (mg_rec_re),
		.rec_rd_addr (mg_rec_raddr),
		.rec_rd_data (rec_rdata),
		.rec_wr_en   (mg_rec_we),
		.rec_wr_addr (mg_rec_waddr),
		.rec_wr_data (mg_rec_wdata),
		.scr_wr_en   (scr_we),
		.scr_wr_addr (scr_waddr),
		.scr_wr_data (scr_wdata),
		.scr_rd_en   (scr_re),
		.scr_rd_addr (scr_raddr),
		.scr_rd_data (scr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_LOAD;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			n_q          <= '0;
			ovf_run_q    <= 1'b0;
			sort_start_q <= 1'b0;
			k_q          <= '0;
			rd_pend_s1   <= 1'b0;
			last_s1      <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tlast      <= 1'b0;
			m_tuser      <= 1'b0;
		end else begin
			sort_start_q <= 1'b0;
			rd_pend_s1   <= emit_issue;
			last_s1      <= (k_q == n_q - CW'(1));

			// output register: drain on transfer, refill from the RAM read
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (rd_pend_s1) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {PAY_FIELD_W'(rec_rdata[PW-1:0]),
				             KEY_FIELD_W'(rec_rdata[DW-1 -: KW])};
				m_tlast  <= last_s1;
				m_tuser  <= ovf_run_q;
			end

			unique case (state_q)
				T_LOAD: begin
					if (in_xfer) begin
						if (store) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q          <= store ? count_q + CW'(1) : count_q;
							ovf_run_q    <= ovf_q || !store;
							count_q      <= '0;
							ovf_q        <= 1'b0;
							sort_start_q <= 1'b1;
							state_q      <= T_SORT;
						end
					end
				end
				T_SORT: begin
					if (sort_finished) begin
						k_q     <= '0;
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (emit_issue) begin
						k_q <= k_q + CW'(1);
						if (k_q == n_q - CW'(1)) begin
							state_q <= T_LOAD;
						end
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/msort_ram.sv
module msort_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/msort_span_stack.sv
module msort_span_stack import msort_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [$clog2(MAX_ITEMS+1)-1:0]   span_len,
	input  logic                             merge_done,
	output msort_job_t                       job,
	output logic                             finished
);

	localparam int AW     = $clog2(MAX_ITEMS);
	localparam int CW     = $clog2(MAX_ITEMS + 1);
	localparam int SDEPTH = $clog2(MAX_ITEMS) + 1;
	localparam int IW     = $clog2(SDEPTH);
	localparam int SPW    = $clog2(SDEPTH + 1);

	typedef enum logic [1:0] {PH_LEFT, PH_RIGHT, PH_MERGE} phase_t;

	typedef struct packed {
		logic [AW-1:0] lo;
		logic [CW-1:0] len;
		phase_t        phase;
	} frame_t;

	typedef enum logic [1:0] {S_IDLE, S_STEP, S_WAIT} state_t;

	state_t         state_q;
	frame_t         top_q;
	frame_t         stk_q [SDEPTH];
	logic [SPW-1:0] sp_q;
	logic [SPW-1:0] sp_dec;
	msort_job_t     job_q;
	logic           finished_q;

	logic [CW-1:0]  half;
	logic [CW-1:0]  rest;
	logic [AW-1:0]  lo_r;
	logic           push;
	frame_t         push_frame;

	assign half   = top_q.len >> 1;
	assign rest   = top_q.len - half;
	assign lo_r   = top_q.lo + half[AW-1:0];
	assign sp_dec = sp_q - SPW'(1);

	// parent frame goes below the child with its phase advanced
	always_comb begin
		push       = 1'b0;
		push_frame = top_q;
		if (state_q == S_STEP) begin
			unique case (top_q.phase)
				PH_LEFT: begin
					push             = (half >= CW'(2));
					push_frame.phase = PH_RIGHT;
				end
				PH_RIGHT: begin
					push             = (rest >= CW'(2));
					push_frame.phase = PH_MERGE;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[sp_q[IW-1:0]] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			top_q      <= '0;
			sp_q       <= '0;
			job_q      <= '0;
			finished_q <= 1'b0;
		end else begin
			job_q.valid <= 1'b0;
			finished_q  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (span_len < CW'(2)) begin
							finished_q <= 1'b1;
						end else begin
							top_q   <= '{lo: '0, len: span_len, phase: PH_LEFT};
							sp_q    <= '0;
							state_q <= S_STEP;
						end
					end
				end
				S_STEP: begin
					unique case (top_q.phase)
						PH_LEFT: begin
							if (push) begin
								top_q <= '{lo: top_q.lo, len: half, phase: PH_LEFT};
								sp_q  <= sp_q + SPW'(1);
							end else begin
								top_q.phase <= PH_RIGHT;
							end
						end
						PH_RIGHT: begin
							if (push) begin
								top_q <= '{lo: lo_r, len: rest, phase: PH_LEFT};
								sp_q  <= sp_q + SPW'(1);
							end else begin
								top_q.phase <= PH_MERGE;
							end
						end
						default: begin
							job_q.valid <= 1'b1;
							job_q.lo    <= POS_W'(top_q.lo);
							job_q.half  <= POS_W'(half);
							job_q.len   <= POS_W'(top_q.len);
							state_q     <= S_WAIT;
						end
					endcase
				end
				S_WAIT: begin
					if (merge_done) begin
						if (sp_q == '0) begin
							finished_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							top_q   <= stk_q[sp_dec[IW-1:0]];
							sp_q    <= sp_dec;
							state_q <= S_STEP;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign job      = job_q;
	assign finished = finished_q;

endmodule

>>> rtl/core/msort_merger.sv
module msort_merger import msort_pkg::*; #(
	parameter int MAX_ITEMS = 64,
	parameter int DW        = 48,
	parameter int KW        = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  msort_job_t                   job,
	output logic                         done,
	output logic                         rec_rd_en,
	output logic [$clog2(MAX_ITEMS)-1:0] rec_rd_addr,
	input  logic [DW-1:0]                rec_rd_data,
	output logic                         rec_wr_en,
	output logic [$clog2(MAX_ITEMS)-1:0] rec_wr_addr,
	output logic [DW-1:0]                rec_wr_data,
	output logic                         scr_wr_en,
	output logic [$clog2(MAX_ITEMS)-1:0] scr_wr_addr,
	output logic [DW-1:0]                scr_wr_data,
	output logic                         scr_rd_en,
	output logic [$clog2(MAX_ITEMS)-1:0] scr_rd_addr,
	input  logic [DW-1:0]                scr_rd_data
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {M_IDLE, M_PRIME_L, M_PRIME_R, M_MERGE, M_TAIL, M_BACK} state_t;

	state_t        state_q;
	logic [AW-1:0] lo_q;
	logic [CW-1:0] li_q, lend_q, ri_q, rend_q, w_q, c_q;
	logic [DW-1:0] lhead_q, rhead_q;
	logic          fresh_r_q;   // 1: right head is on the read port, else left
	logic          wr_v_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          done_q;

	logic [CW-1:0] job_lo, job_mid;
	logic [DW-1:0] l_cur, r_cur;
	logic          take_l;
	logic [CW-1:0] li_nx, ri_nx;

	assign job_lo  = job.lo[CW-1:0];
	assign job_mid = job.lo[CW-1:0] + job.half[CW-1:0];

	assign l_cur  = fresh_r_q ? lhead_q : rec_rd_data;
	assign r_cur  = fresh_r_q ? rec_rd_data : rhead_q;
	// ties go to the right half
	assign take_l = l_cur[DW-1 -: KW] < r_cur[DW-1 -: KW];
	assign li_nx  = li_q + CW'(1);
	assign ri_nx  = ri_q + CW'(1);

	always_comb begin
		rec_rd_en   = 1'b0;
		rec_rd_addr = li_q[AW-1:0];
		scr_wr_en   = 1'b0;
		scr_wr_addr = w_q[AW-1:0];
		scr_wr_data = l_cur;
		scr_rd_en   = 1'b0;
		scr_rd_addr = c_q[AW-1:0];
		unique case (state_q)
			M_PRIME_L: begin
				rec_rd_en = 1'b1;
			end
			M_PRIME_R: begin
				rec_rd_en   = 1'b1;
				rec_rd_addr = ri_q[AW-1:0];
			end
			M_MERGE: begin
				scr_wr_en = 1'b1;
				if (take_l) begin
					rec_rd_en   = (li_nx != lend_q);
					rec_rd_addr = li_nx[AW-1:0];
				end else begin
					scr_wr_data = r_cur;
					rec_rd_en   = 1'b1;
					// right run ends: re-read the left head for the tail copy
					rec_rd_addr = (ri_nx != rend_q) ? ri_nx[AW-1:0] : li_q[AW-1:0];
				end
			end
			M_TAIL: begin
				scr_wr_en   = 1'b1;
				scr_wr_data = rec_rd_data;
				rec_rd_en   = (li_nx != lend_q);
				rec_rd_addr = li_nx[AW-1:0];
			end
			M_BACK: begin
				scr_rd_en = 1'b1;
			end
			default: begin
				rec_rd_en = 1'b0;
			end
		endcase
	end

	assign rec_wr_en   = wr_v_s1;
	assign rec_wr_addr = wr_addr_s1;
	assign rec_wr_data = scr_rd_data;
	assign done        = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= M_IDLE;
			lo_q       <= '0;
			li_q       <= '0;
			lend_q     <= '0;
			ri_q       <= '0;
			rend_q     <= '0;
			w_q        <= '0;
			c_q        <= '0;
			lhead_q    <= '0;
			rhead_q    <= '0;
			fresh_r_q  <= 1'b0;
			wr_v_s1    <= 1'b0;
			wr_addr_s1 <= '0;
			done_q     <= 1'b0;
		end else begin
			wr_v_s1    <= (state_q == M_BACK);
			wr_addr_s1 <= lo_q + c_q[AW-1:0];
			done_q     <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (job.valid) begin
						lo_q    <= job.lo[AW-1:0];
						li_q    <= job_lo;
						lend_q  <= job_mid;
						ri_q    <= job_mid;
						rend_q  <= job_lo + job.len[CW-1:0];
						w_q     <= '0;
						state_q <= M_PRIME_L;
					end
				end
				M_PRIME_L: begin
					state_q <= M_PRIME_R;
				end
				M_PRIME_R: begin
					lhead_q   <= rec_rd_data;
					fresh_r_q <= 1'b1;
					state_q   <= M_MERGE;
				end
				M_MERGE: begin
					lhead_q <= l_cur;
					rhead_q <= r_cur;
					w_q     <= w_q + CW'(1);
					if (take_l) begin
						li_q      <= li_nx;
						fresh_r_q <= 1'b0;
						if (li_nx == lend_q) begin
							// right remainder already sits in place
							c_q     <= '0;
							state_q <= M_BACK;
						end
					end else begin
						ri_q      <= ri_nx;
						fresh_r_q <= 1'b1;
						if (ri_nx == rend_q) begin
							state_q <= M_TAIL;
						end
					end
				end
				M_TAIL: begin
					w_q  <= w_q + CW'(1);
					li_q <= li_nx;
					if (li_nx == lend_q) begin
						c_q     <= '0;
						state_q <= M_BACK;
					end
				end
				M_BACK: begin
					c_q <= c_q + CW'(1);
					if (c_q == w_q - CW'(1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sim/tb.sv
module tb import msort_pkg::*;;

	localparam int MAX_RECS    = 64;
	localparam int DIR_ROWS    = 25;
	localparam int ITEM_TARGET = 350;    // no new set starts once this many records went in
	localparam int QUIET_AT    = 290;    // no idling on either side past this point
	localparam int TAIL_CYCLES = 64;     // settle time after the last sorted record
	localparam int CYCLE_LIMIT = 400000; // watchdog

	// one sorted record as it leaves the block
	typedef struct packed {
		logic [KEY_FIELD_W-1:0] key;
		logic [PAY_FIELD_W-1:0] pay;
		logic                   last;
		logic                   ovf;
	} sorted_rec_t;

	// directed row: input record, plus a typed-in result for one-record sets
	typedef struct packed {
		logic [KEY_FIELD_W-1:0] key;
		logic [PAY_FIELD_W-1:0] pay;
		logic                   last;
		logic                   typed;
		sorted_rec_t            want;
	} dir_row_t;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;  // record_key [31:0], record_payload [47:32]
	logic               s_tlast  = 1'b0; // final_record
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;  // sorted_key [31:0], sorted_payload [47:32]
	logic               m_tlast;  // last_out
	logic               m_tuser;  // overflowed

	merge_sort_engine #(
		.MAX_ITEMS   (MAX_RECS),
		.KEY_BITS    (KEY_FIELD_W),
		.PAYLOAD_BITS(PAY_FIELD_W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	// Directed sets. Single-record sets carry their result inline; the
	// longer sets (ties, extremes, reversed and in-order runs) go through
	// the sort model.
	dir_row_t dir_tab [DIR_ROWS] = '{
		// single records: all zeros, all ones, top bit only
		'{32'h0000_0000, 16'h0000, 1'b1, 1'b1, '{32'h0000_0000, 16'h0000, 1'b1, 1'b0}},
		'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0}},
		'{32'h8000_0000, 16'h8001, 1'b1, 1'b1, '{32'h8000_0000, 16'h8001, 1'b1, 1'b0}},
		// ties across merge halves: right side leaves first
		'{32'h0000_0005, 16'h0001, 1'b0, 1'b0, '0},
		'{32'h0000_0005, 16'h0002, 1'b0, 1'b0, '0},
		'{32'h0000_0003, 16'h0003, 1'b0, 1'b0, '0},
		'{32'h0000_0005, 16'h0004, 1'b1, 1'b0, '0},
		// key extremes, unsigned compare
		'{32'hFFFF_FFFF, 16'h1234, 1'b0, 1'b0, '0},
		'{32'h0000_0000, 16'hABCD, 1'b0, 1'b0, '0},
		'{32'h7FFF_FFFF, 16'h5555, 1'b1, 1'b0, '0},
		// two equal keys
		'{32'h0000_0009, 16'h0001, 1'b0, 1'b0, '0},
		'{32'h0000_0009, 16'h0002, 1'b1, 1'b0, '0},
		// reversed run
		'{32'h0000_0050, 16'h0010, 1'b0, 1'b0, '0},
		'{32'h0000_0040, 16'h0020, 1'b0, 1'b0, '0},
		'{32'h0000_0030, 16'h0030, 1'b0, 1'b0, '0},
		'{32'h0000_0020, 16'h0040, 1'b0, 1'b0, '0},
		'{32'h0000_0010, 16'h0050, 1'b1, 1'b0, '0},
		// already in order
		'{32'h0000_0001, 16'hAAAA, 1'b0, 1'b0, '0},
		'{32'h0000_0002, 16'h5555, 1'b0, 1'b0, '0},
		'{32'h0000_0003, 16'hAAAA, 1'b0, 1'b0, '0},
		'{32'h0000_0004, 16'h5555, 1'b0, 1'b0, '0},
		'{32'h0000_0005, 16'hAAAA, 1'b1, 1'b0, '0},
		// all keys equal at the top
		'{32'hFFFF_FFFF, 16'h0001, 1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF, 16'h0002, 1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF, 16'h0003, 1'b1, 1'b0, '0}
	};

	// sort model state: records of the set being collected, merge scratch
	logic [KEY_FIELD_W-1:0] held_key [MAX_RECS];
	logic [PAY_FIELD_W-1:0] held_pay [MAX_RECS];
	logic [KEY_FIELD_W-1:0] merge_key [MAX_RECS];
	logic [PAY_FIELD_W-1:0] merge_pay [MAX_RECS];
	int unsigned            held_cnt = 0;
	bit                     held_lost = 1'b0;

	sorted_rec_t sorted_due_q [$]; // sorted records still owed by the block
	sorted_rec_t due_rec;
	int unsigned fails      = 0;
	int unsigned items_sent = 0;
	int unsigned cycles     = 0;
	bit          quiet      = 1'b0; // end of run: no idling at all
	bit          calm       = 1'b0; // current set goes in back to back

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// top-down merge sort, split at n/2; on equal keys the right record wins
	function automatic void merge_span(int unsigned lo, int unsigned n);
		int unsigned nl, nr, li, ri, w, k;
		if (n <= 1) return;
		nl = n / 2;
		nr = n - nl;
		merge_span(lo, nl);
		merge_span(lo + nl, nr);
		li = lo;
		ri = lo + nl;
		w  = 0;
		while (nl > 0 && nr > 0) begin
			if (held_key[li] < held_key[ri]) begin
				merge_key[w] = held_key[li];
				merge_pay[w] = held_pay[li];
				li++;
				nl--;
			end else begin
				merge_key[w] = held_key[ri];
				merge_pay[w] = held_pay[ri];
				ri++;
				nr--;
			end
			w++;
		end
		while (nl > 0) begin
			merge_key[w] = held_key[li];
			merge_pay[w] = held_pay[li];
			li++;
			nl--;
			w++;
		end
		// a right tail left over is already in place
		for (k = 0; k < w; k++) begin
			held_key[lo + k] = merge_key[k];
			held_pay[lo + k] = merge_pay[k];
		end
	endfunction

	// Account for one accepted record; on the final one, sort the set and
	// queue the sorted run (or the typed-in result for a directed row).
	function automatic void take_record(logic [KEY_FIELD_W-1:0] key,
		logic [PAY_FIELD_W-1:0] pay, bit last, bit typed, sorted_rec_t want);
		sorted_rec_t rec;
		int unsigned k;
		if (held_cnt < MAX_RECS) begin
			held_key[held_cnt] = key;
			held_pay[held_cnt] = pay;
			held_cnt++;
		end else begin
			held_lost = 1'b1; // store full: record dropped, even a final one
		end
		if (!last) return;
		merge_span(0, held_cnt);
		if (typed) begin
			sorted_due_q.push_back(want);
		end else begin
			for (k = 0; k < held_cnt; k++) begin
				rec.key  = held_key[k];
				rec.pay  = held_pay[k];
				rec.last = (k + 1 == held_cnt);
				rec.ovf  = held_lost;
				sorted_due_q.push_back(rec);
			end
		end
		held_cnt  = 0;
		held_lost = 1'b0;
	endfunction

	// One record in: optional idle burst, then hold tvalid until the transfer.
	task automatic send_record(input logic [KEY_FIELD_W-1:0] key,
		input logic [PAY_FIELD_W-1:0] pay, input bit last, input bit typed,
		input sorted_rec_t want);
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pay, key};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		take_record(key, pay, last, typed, want);
		items_sent++;
		if (items_sent >= QUIET_AT) quiet = 1'b1;
	endtask

	task automatic wait_sorted_drained();
		while (sorted_due_q.size() != 0) @(posedge clk);
	endtask

	// receiver: stalls in bursts, none at the end of the run
	initial begin : rx_pacing
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				hold = $urandom_range(0, 10);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// output checker: every transfer against the oldest owed record
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_due_q.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual key %h payload %h",
					$time, m_tdata[31:0], m_tdata[47:32]);
				fails++;
			end else begin
				due_rec = sorted_due_q.pop_front();
				if (m_tdata[31:0] !== due_rec.key) begin
					$display("%0t: sorted_key expected %h actual %h",
						$time, due_rec.key, m_tdata[31:0]);
					fails++;
				end
				if (m_tdata[47:32] !== due_rec.pay) begin
					$display("%0t: sorted_payload expected %h actual %h",
						$time, due_rec.pay, m_tdata[47:32]);
					fails++;
				end
				if (m_tlast !== due_rec.last) begin
					$display("%0t: last_out expected %b actual %b",
						$time, due_rec.last, m_tlast);
					fails++;
				end
				if (m_tuser !== due_rec.ovf) begin
					$display("%0t: overflowed expected %b actual %b",
						$time, due_rec.ovf, m_tuser);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned            set_no, set_len, key_mode, i;
		logic [KEY_FIELD_W-1:0] key;
		set_no = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIR_ROWS; i++)
			send_record(dir_tab[i].key, dir_tab[i].pay, dir_tab[i].last,
				dir_tab[i].typed, dir_tab[i].want);
		s_tvalid <= 1'b0;
		// hold off until the directed sets are fully out
		wait_sorted_drained();

		// Random sets. The first two fill the store exactly and then
		// overrun it (dropping a plain record and the final one); later
		// sets are mostly short, with a few mid-size and the odd overrun.
		while (items_sent < ITEM_TARGET) begin
			case (set_no)
				0: set_len = MAX_RECS;
				1: set_len = MAX_RECS + 2;
				default: begin
					case ($urandom_range(0, 24))
						0:       set_len = $urandom_range(MAX_RECS, MAX_RECS + 6);
						1, 2, 3: set_len = $urandom_range(9, 40);
						default: set_len = $urandom_range(1, 8);
					endcase
				end
			endcase
			key_mode = $urandom_range(0, 3);
			calm     = ($urandom_range(0, 3) == 0);
			for (i = 0; i < set_len; i++) begin
				case (key_mode)
					1: key = $urandom_range(0, 7); // dense ties
					2: begin
						case ($urandom_range(0, 4))
							0:       key = 32'h0000_0000;
							1:       key = 32'hFFFF_FFFF;
							2:       key = 32'h8000_0000;
							3:       key = 32'h7FFF_FFFF;
							default: key = $urandom;
						endcase
					end
					default: key = $urandom;
				endcase
				send_record(key, PAY_FIELD_W'($urandom_range(0, 16'hFFFF)),
					i == set_len - 1, 1'b0, '0);
			end
			if (set_no == 1) begin
				s_tvalid <= 1'b0;
				wait_sorted_drained();
			end
			set_no++;
		end
		s_tvalid <= 1'b0;

		wait_sorted_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/msort_pkg.sv
rtl/core/msort_ram.sv
rtl/core/msort_span_stack.sv
rtl/core/msort_merger.sv
rtl/core/merge_sort_engine.sv
sim/tb.sv
